>>> hw/rtl/source_text_tokenizer_unit_defines.svh
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_DEFINES_SVH
// Assertion macros; clk and rst of the including module are used.
`ifndef ASSERT_OFF
`define STT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define STT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define STT_ASSERT(lbl, prop)
`define STT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/stt_pkg.sv
package stt_pkg;

  localparam int MAX_COMMENT_DEPTH = 15;
  localparam int POSITION_BITS = 16;
  localparam int DEPTH_BITS = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam int NKW = 9;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_SEMI = 6'd4;
  localparam logic [5:0] K_COMMA = 6'd5;
  localparam logic [5:0] K_DOT = 6'd6;
  localparam logic [5:0] K_AMP = 6'd7;
  localparam logic [5:0] K_PLUS = 6'd8;
  localparam logic [5:0] K_MINUS = 6'd9;
  localparam logic [5:0] K_STAR = 6'd10;
  localparam logic [5:0] K_SLASH = 6'd11;
  localparam logic [5:0] K_LT = 6'd12;
  localparam logic [5:0] K_LE = 6'd13;
  localparam logic [5:0] K_GT = 6'd14;
  localparam logic [5:0] K_GE = 6'd15;
  localparam logic [5:0] K_ASSIGN = 6'd16;
  localparam logic [5:0] K_EQ = 6'd17;
  localparam logic [5:0] K_ARROW = 6'd18;
  localparam logic [5:0] K_IDENT = 6'd19;
  localparam logic [5:0] K_NUM = 6'd20;
  localparam logic [5:0] K_STR = 6'd21;
  localparam logic [5:0] K_KW0 = 6'd22;
  localparam logic [5:0] K_EOF = 6'd31;
  localparam logic [5:0] K_UNKNOWN = 6'd32;

  localparam logic [2:0] E_NONE = 3'd0;
  localparam logic [2:0] E_BAD_ESC = 3'd1;
  localparam logic [2:0] E_SECOND_DOT = 3'd2;
  localparam logic [2:0] E_UNTERM = 3'd3;
  localparam logic [2:0] E_DEPTH = 3'd4;

  typedef enum logic [3:0] {
    M_IDLE, M_HELD, M_IDENT, M_NUM, M_STR, M_STR_ESC, M_LINE, M_BLOCK
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic [POSITION_BITS-1:0] line;
    logic [POSITION_BITS-1:0] col;
    logic [POSITION_BITS-1:0] tok_line;
    logic [POSITION_BITS-1:0] tok_col;
    logic [15:0] size;
    logic [7:0] held;
    logic [NKW-1:0] kw;
    logic seen_dot;
    logic [DEPTH_BITS-1:0] depth;
    logic finished;
    logic [2:0] perr;
  } state_t;

  typedef struct packed {
    logic is_content;
    logic [5:0] token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] token_length;
    logic has_dot;
    logic [7:0] content_byte;
    logic [2:0] error_code;
    logic last_of_run;
  } res_t;

  localparam logic [2:0] KW_LEN [NKW] = '{3'd2, 3'd6, 3'd4, 3'd2, 3'd4, 3'd6, 3'd3, 3'd4, 3'd5};
  localparam logic [7:0] KW_TEXT [NKW][6] = '{
    '{"f", "n", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"e", "x", "t", "e", "r", "n"},
    '{"c", "a", "s", "t", 8'h0, 8'h0},
    '{"i", "f", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"e", "l", "s", "e", 8'h0, 8'h0},
    '{"s", "t", "r", "u", "c", "t"},
    '{"l", "e", "t", 8'h0, 8'h0, 8'h0},
    '{"l", "o", "o", "p", 8'h0, 8'h0},
    '{"b", "r", "e", "a", "k", 8'h0}
  };

  // Drop every keyword that cannot match character c at position idx.
  function automatic logic [NKW-1:0] kw_filter(logic [NKW-1:0] cand, logic [7:0] c,
                                                logic [15:0] idx);
    logic [NKW-1:0] r;
    r = cand;
    for (int k = 0; k < NKW; k++) begin
      if (idx >= 16'(KW_LEN[k])) r[k] = 1'b0;
      else if (KW_TEXT[k][idx[2:0]] != c) r[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [5:0] ident_kind(logic [NKW-1:0] cand, logic [15:0] size);
    logic [5:0] r;
    r = K_IDENT;
    for (int k = NKW - 1; k >= 0; k--) begin
      if (cand[k] && size == 16'(KW_LEN[k])) r = K_KW0 + 6'(k);
    end
    return r;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

endpackage

>>> hw/rtl/byte_stream_if.sv
interface byte_stream_if import stt_pkg::*; ();
  logic valid;
  logic ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

>>> hw/rtl/token_stream_if.sv
interface token_stream_if import stt_pkg::*; ();
  logic valid;
  logic ready;
  logic is_content;
  logic [5:0] token_kind;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [15:0] token_length;
  logic has_dot;
  logic [7:0] content_byte;
  logic [2:0] error_code;
  logic last_of_run;
  modport source (output valid, output is_content, output token_kind, output start_line,
                  output start_column, output token_length, output has_dot,
                  output content_byte, output error_code, output last_of_run, input ready);
  modport sink (input valid, input is_content, input token_kind, input start_line,
                input start_column, input token_length, input has_dot,
                input content_byte, input error_code, input last_of_run, output ready);
endinterface

>>> hw/rtl/stt_step.sv
module stt_step import stt_pkg::*; (
  input  state_t     st,
  input  logic [7:0] c,
  output state_t     st_next,
  output logic [1:0] count,
  output res_t       r0,
  output res_t       r1
);

  function automatic res_t mk(logic content, logic [5:0] kind, logic [POSITION_BITS-1:0] tl,
                              logic [POSITION_BITS-1:0] tc, logic [15:0] len, logic dot,
                              logic [7:0] b, logic [2:0] err);
    res_t r;
    r.is_content = content;
    r.token_kind = kind;
    r.start_line = 16'(tl);
    r.start_column = 16'(tc);
    r.token_length = len;
    r.has_dot = dot;
    r.content_byte = b;
    r.error_code = err;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  state_t s;
  logic   do_start, e1, e2;
  res_t   x1, x2;
  logic   nl;

  always_comb begin
    s = st;
    do_start = 1'b0;
    e1 = 1'b0;
    e2 = 1'b0;
    x1 = '0;
    x2 = '0;
    nl = (c == 8'h0A) || (c == 8'h0D);
    unique case (st.mode)
      M_HELD: begin
        s.held = 8'h0;
        s.mode = M_IDLE;
        e1 = 1'b1;
        x1 = mk(1'b0, K_SLASH, s.tok_line, s.tok_col, 16'd2, 1'b0, 8'h0, E_NONE);
        if (st.held == "<" && c == "=") x1.token_kind = K_LE;
        else if (st.held == ">" && c == "=") x1.token_kind = K_GE;
        else if (st.held == "=" && c == "=") x1.token_kind = K_EQ;
        else if (st.held == "-" && c == ">") x1.token_kind = K_ARROW;
        else if (st.held == "/" && c == "/") begin
          e1 = 1'b0;
          s.mode = M_LINE;
        end else if (st.held == "/" && c == "*") begin
          e1 = 1'b0;
          s.depth = DEPTH_BITS'(1);
          s.mode = M_BLOCK;
        end else begin
          x1.token_length = 16'd1;
          if (st.held == "<") x1.token_kind = K_LT;
          else if (st.held == ">") x1.token_kind = K_GT;
          else if (st.held == "=") x1.token_kind = K_ASSIGN;
          else if (st.held == "-") x1.token_kind = K_MINUS;
          do_start = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (st.size < LEN_MAX) begin
            s.kw = kw_filter(st.kw, c, st.size);
            s.size = st.size + 16'd1;
          end else begin
            s.kw = '0;
          end
        end else begin
          e1 = 1'b1;
          x1 = mk(1'b0, ident_kind(st.kw, st.size), st.tok_line, st.tok_col, st.size,
                  1'b0, 8'h0, E_NONE);
          do_start = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit(c) || c == ".") begin
          if (c == ".") begin
            if (st.seen_dot) s.perr = E_SECOND_DOT;
            s.seen_dot = 1'b1;
          end
          if (st.size < LEN_MAX) s.size = st.size + 16'd1;
        end else begin
          e1 = 1'b1;
          x1 = mk(1'b0, K_NUM, st.tok_line, st.tok_col, st.size, st.seen_dot, 8'h0, st.perr);
          do_start = 1'b1;
        end
      end
      M_STR, M_STR_ESC: begin
        if (c == 8'h0) begin
          e1 = 1'b1;
          x1 = mk(1'b0, K_STR, st.tok_line, st.tok_col, st.size, 1'b0, 8'h0, E_UNTERM);
          do_start = 1'b1;
        end else if (st.mode == M_STR_ESC) begin
          s.mode = M_STR;
          if (c == "n" || c == "r" || c == "t") begin
            if (st.size < LEN_MAX) s.size = st.size + 16'd1;
            e1 = 1'b1;
            x1 = mk(1'b1, K_STR, st.tok_line, st.tok_col, s.size, 1'b0,
                    (c == "n") ? 8'h0A : (c == "r") ? 8'h0D : 8'h09, E_NONE);
          end else begin
            s.perr = E_BAD_ESC;
            if (c == "\"") begin
              e1 = 1'b1;
              x1 = mk(1'b0, K_STR, st.tok_line, st.tok_col, st.size, 1'b0, 8'h0, E_BAD_ESC);
              s.mode = M_IDLE;
            end
          end
        end else if (c == "\"") begin
          e1 = 1'b1;
          x1 = mk(1'b0, K_STR, st.tok_line, st.tok_col, st.size, 1'b0, 8'h0, st.perr);
          s.mode = M_IDLE;
        end else if (c == "\\") begin
          s.mode = M_STR_ESC;
        end else begin
          if (st.size < LEN_MAX) s.size = st.size + 16'd1;
          e1 = 1'b1;
          x1 = mk(1'b1, K_STR, st.tok_line, st.tok_col, s.size, 1'b0, c, E_NONE);
        end
      end
      M_LINE: begin
        if (c == 8'h0) do_start = 1'b1;
        else if (nl) s.mode = M_IDLE;
      end
      M_BLOCK: begin
        if (c == 8'h0) begin
          s.tok_line = st.line;
          s.tok_col = st.col;
          e1 = 1'b1;
          x1 = mk(1'b0, K_EOF, st.line, st.col, 16'd1, 1'b0, 8'h0, E_UNTERM);
          s.finished = 1'b1;
        end else if (st.held == "/" && c == "*") begin
          s.held = 8'h0;
          if (st.depth >= DEPTH_BITS'(MAX_COMMENT_DEPTH)) begin
            e1 = 1'b1;
            x1 = mk(1'b0, K_UNKNOWN, st.tok_line, st.tok_col, 16'd2, 1'b0, 8'h0, E_DEPTH);
          end else begin
            s.depth = st.depth + DEPTH_BITS'(1);
          end
        end else if (st.held == "*" && c == "/") begin
          s.held = 8'h0;
          if (st.depth != '0) s.depth = st.depth - DEPTH_BITS'(1);
          if (s.depth == '0) s.mode = M_IDLE;
        end else if (c == "/" || c == "*") begin
          s.held = c;
          s.tok_line = st.line;
          s.tok_col = st.col;
        end else begin
          s.held = 8'h0;
        end
      end
      default: do_start = 1'b1;
    endcase

    if (do_start) begin
      s.tok_line = st.line;
      s.tok_col = st.col;
      s.mode = M_IDLE;
      x2 = mk(1'b0, K_UNKNOWN, st.line, st.col, 16'd1, 1'b0, 8'h0, E_NONE);
      e2 = 1'b1;
      priority case (c)
        8'h00: begin
          x2.token_kind = K_EOF;
          s.finished = 1'b1;
        end
        " ", 8'h09, 8'h0A, 8'h0D: e2 = 1'b0;
        "(": x2.token_kind = K_LPAREN;
        ")": x2.token_kind = K_RPAREN;
        "{": x2.token_kind = K_LBRACE;
        "}": x2.token_kind = K_RBRACE;
        ";": x2.token_kind = K_SEMI;
        ",": x2.token_kind = K_COMMA;
        ".": x2.token_kind = K_DOT;
        "&": x2.token_kind = K_AMP;
        "+": x2.token_kind = K_PLUS;
        "*": x2.token_kind = K_STAR;
        "<", ">", "=", "-", "/": begin
          e2 = 1'b0;
          s.held = c;
          s.mode = M_HELD;
        end
        "\"": begin
          e2 = 1'b0;
          s.size = 16'd0;
          s.perr = E_NONE;
          s.mode = M_STR;
        end
        default: begin
          if (is_alpha(c)) begin
            e2 = 1'b0;
            s.kw = kw_filter({NKW{1'b1}}, c, 16'd0);
            s.size = 16'd1;
            s.mode = M_IDENT;
          end else if (is_digit(c)) begin
            e2 = 1'b0;
            s.size = 16'd1;
            s.seen_dot = 1'b0;
            s.perr = E_NONE;
            s.mode = M_NUM;
          end
        end
      endcase
    end

    if (nl) begin
      if (st.line < POS_MAX) s.line = st.line + POSITION_BITS'(1);
      s.col = POSITION_BITS'(1);
    end else if (st.col < POS_MAX) begin
      s.col = st.col + POSITION_BITS'(1);
    end

    r0 = e1 ? x1 : x2;
    r1 = x2;
    r0.last_of_run = !(e1 && e2);
    r1.last_of_run = 1'b1;
    count = {1'b0, e1} + {1'b0, e2};

    // A finished stream ignores every byte.
    if (st.finished) begin
      s = st;
      count = 2'd0;
    end
    st_next = s;
  end

endmodule

>>> hw/rtl/stt_fifo.sv
module stt_fifo import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push,
  input  res_t       d0,
  input  res_t       d1,
  input  logic       pop,
  output res_t       q,
  output logic       not_empty,
  output logic       room2
);

  res_t       mem [4];
  logic [1:0] wp, rp;
  logic [2:0] fill;

  assign q = mem[rp];
  assign not_empty = fill != 3'd0;
  assign room2 = fill <= 3'd2;

  always_ff @(posedge clk) begin
    if (push != 2'd0) mem[wp] <= d0;
    if (push == 2'd2) mem[wp + 2'd1] <= d1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      wp <= wp + push;
      rp <= rp + {1'b0, pop};
      fill <= fill + {1'b0, push} - {2'b0, pop};
    end
  end

endmodule

>>> hw/rtl/source_text_tokenizer_unit.sv
// A taken byte's results are registered into the result queue and offered at its head; a
// second result follows in the cycle after the first one is taken. Throughput: one byte
// per cycle while the queue has room for two results; each byte updates the scan state in a
// single pass. The four-entry queue takes up to two results per byte, drains one per cycle
// to a ready sink. Reset (rst, synchronous): idle scan mode, line 1, column 1, queue empty.
`include "source_text_tokenizer_unit_defines.svh"
module source_text_tokenizer_unit import stt_pkg::*; (
  input logic           clk,
  input logic           rst,
  byte_stream_if.sink   src,
  token_stream_if.source dst
);

  state_t     st, st_next;
  logic [1:0] n_res;
  res_t       r0, r1, q;
  logic       acc, pop, not_empty, room2;

  // Take a byte only while the queue has room for two results.
  assign src.ready = room2;
  assign acc = src.valid && src.ready;
  assign pop = dst.valid && dst.ready;

  stt_step u_step (
    .st(st), .c(src.in_byte), .st_next(st_next), .count(n_res), .r0(r0), .r1(r1)
  );

  stt_fifo u_fifo (
    .clk(clk), .rst(rst), .push(acc ? n_res : 2'd0), .d0(r0), .d1(r1), .pop(pop),
    .q(q), .not_empty(not_empty), .room2(room2)
  );

  // Hold scan state between bytes; advance on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{mode: M_IDLE, line: POSITION_BITS'(1), col: POSITION_BITS'(1),
              tok_line: '0, tok_col: '0, size: '0, held: '0, kw: {NKW{1'b1}},
              seen_dot: 1'b0, depth: '0, finished: 1'b0, perr: E_NONE};
    end else if (acc) begin
      st <= st_next;
    end
  end

  assign dst.valid = not_empty;
  assign dst.is_content = q.is_content;
  assign dst.token_kind = q.token_kind;
  assign dst.start_line = q.start_line;
  assign dst.start_column = q.start_column;
  assign dst.token_length = q.token_length;
  assign dst.has_dot = q.has_dot;
  assign dst.content_byte = q.content_byte;
  assign dst.error_code = q.error_code;
  assign dst.last_of_run = q.last_of_run;

  `STT_ASSERT(a_depth_bound, st.depth <= DEPTH_BITS'(MAX_COMMENT_DEPTH))
  `STT_ASSERT(a_stall_has_output, !src.ready |-> dst.valid)
  `STT_ASSERT_NEXT(a_finished_frozen, acc && st.finished, $stable(st))

endmodule
